// File: hw/rtl/crc32cfr_pkg.sv
`default_nettype none

package crc32cfr_pkg;

  localparam logic [7:0]  StartByte = 8'hAA;
  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;
  localparam int          CrcBytes  = 4;

  // Receive phases
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_ARG    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC    = 3'd5
  } phase_e;

  // One result item
  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_arg;
    logic [15:0] frame_length;
    logic        crc_ok;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
  } result_t;

  typedef logic [31:0] crc_table_t [256];

  // Byte-wise lookup table for the reflected CRC-32, built at elaboration
  function automatic crc_table_t crc_table_gen();
    crc_table_t  tbl;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crc32_checked_frame_receiver.sv
`default_nettype none

// Length-prefixed frame receiver with CRC-32 check. Bytes arrive on rx_byte_i;
// anything before a 0xAA start byte is dropped. The header is a little-endian
// 16-bit length and an argument byte; each payload byte is passed out as a
// result (out_kind_o = 0) while a reflected CRC-32 (poly 0xEDB88320, init all
// ones, final inversion) runs over it, one table lookup per byte. Four
// little-endian CRC bytes follow and produce one status result (out_kind_o = 1)
// with crc_ok_o. A start byte inside a frame is plain data. One byte is taken
// every clock cycle unless in_stall_o is high; the frame state and CRC update
// in the cycle of the transfer, and a result is registered into the output
// register, or the skid register if the output stalls. This two-entry
// output stage lets input keep flowing while the output side stalls;
// in_stall_o rises only when both entries are full.
module crc32_checked_frame_receiver
  import crc32cfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      payload_index_o,
  output logic [7:0]       frame_arg_o,
  output logic [15:0]      frame_length_o,
  output logic             crc_ok_o,
  output logic [31:0]      received_crc_o,
  output logic [31:0]      computed_crc_o
);

  localparam crc_table_t CrcTable = crc_table_gen();

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  arg_q, arg_d;
  logic [15:0] cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] shift_q, shift_d;

  logic        in_xfer;
  logic        res_valid;
  result_t     res;
  logic [15:0] cnt_inc;
  logic [31:0] crc_next;
  logic [31:0] computed;
  logic [31:0] shift_next;

  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;
  logic        out_free;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Per-byte datapath terms
  assign cnt_inc    = cnt_q + 16'd1;
  assign crc_next   = CrcTable[crc_q[7:0] ^ rx_byte_i] ^ (crc_q >> 8);
  assign computed   = ~crc_q;
  assign shift_next = {rx_byte_i, shift_q[31:8]};

  // Frame state machine: next state and result
  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    arg_d     = arg_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    shift_d   = shift_q;
    res_valid = 1'b0;
    res       = '0;
    if (in_xfer) begin
      case (phase_q)
        PH_LEN_LO: begin
          len_d   = {8'h00, rx_byte_i};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = {rx_byte_i, len_q[7:0]};
          phase_d = PH_ARG;
        end
        PH_ARG: begin
          arg_d   = rx_byte_i;
          cnt_d   = '0;
          crc_d   = CrcInit;
          shift_d = '0;
          phase_d = (len_q == 16'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          res_valid         = 1'b1;
          res.out_kind      = 1'b0;
          res.payload_byte  = rx_byte_i;
          res.payload_index = cnt_q;
          res.frame_arg     = arg_q;
          res.frame_length  = len_q;
          crc_d             = crc_next;
          cnt_d             = cnt_inc;
          if (cnt_inc >= len_q) begin
            cnt_d   = '0;
            shift_d = '0;
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          shift_d = shift_next;
          cnt_d   = cnt_inc;
          if (cnt_inc >= 16'(CrcBytes)) begin
            res_valid        = 1'b1;
            res.out_kind     = 1'b1;
            res.frame_arg    = arg_q;
            res.frame_length = len_q;
            res.crc_ok       = (shift_next == computed);
            res.received_crc = shift_next;
            res.computed_crc = computed;
            cnt_d            = '0;
            crc_d            = CrcInit;
            phase_d          = PH_HUNT;
          end
        end
        default: begin
          // hunt, and unused codes
          if (rx_byte_i == StartByte) begin
            len_d   = '0;
            phase_d = PH_LEN_LO;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      arg_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= CrcInit;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      arg_q   <= arg_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      shift_q <= shift_d;
    end
  end

  // Output register with skid entry
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_q.out_kind;
  assign payload_byte_o  = out_q.payload_byte;
  assign payload_index_o = out_q.payload_index;
  assign frame_arg_o     = out_q.frame_arg;
  assign frame_length_o  = out_q.frame_length;
  assign crc_ok_o        = out_q.crc_ok;
  assign received_crc_o  = out_q.received_crc;
  assign computed_crc_o  = out_q.computed_crc;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_crc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CRC) |-> (cnt_q < 16'(CrcBytes)))
    else $error("CRC byte count out of range");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < len_q))
    else $error("payload count reached length inside payload phase");

  a_status_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_kind) |->
      (out_q.crc_ok == (out_q.received_crc == out_q.computed_crc)))
    else $error("status match flag disagrees with CRC values");

endmodule

`default_nettype wire
